// ----- rtl/bnk_pkg.sv -----
// ----------------------------------------------------------------------------
// bnk_pkg
// Shared types and codes for the deadlock-avoidance engine.
// ----------------------------------------------------------------------------
package bnk_pkg;
  localparam int ActionW = 3;
  localparam int ProcW   = 3;
  localparam int ResW    = 2;
  localparam int AmtW    = 8;
  localparam int StatusW = 3;

  typedef enum logic [ActionW-1:0] {
    ACT_SET_AVAIL = 3'd0,
    ACT_SET_MAX   = 3'd1,
    ACT_SET_ALLOC = 3'd2,
    ACT_SET_REQ   = 3'd3,
    ACT_CHECK     = 3'd4,
    ACT_SUBMIT    = 3'd5
  } action_t;

  typedef enum logic [StatusW-1:0] {
    ST_LOADED  = 3'd0,
    ST_INVALID = 3'd1,
    ST_SAFE    = 3'd2,
    ST_UNSAFE  = 3'd3,
    ST_EXCEEDS = 3'd4,
    ST_WAIT    = 3'd5,
    ST_GRANTED = 3'd6
  } status_t;

  localparam logic [0:0] REG_NUM_PROCS = 1'b0;
  localparam logic [0:0] REG_NUM_RES   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_REQ_NEED,
    S_REQ_AVAIL,
    S_REQ_APPLY,
    S_CHK_INIT,
    S_CHK_CMP,
    S_CHK_ADD,
    S_CHK_NEXT,
    S_CHK_END,
    S_ROLLBACK,
    S_EMIT,
    S_OUT
  } state_t;

  typedef struct packed {
    action_t    action;
    logic [ProcW-1:0] process_index;
    logic [ResW-1:0]  resource_index;
    logic [AmtW-1:0]  amount;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ProcW-1:0]   seq_process;
    logic               seq_valid;
    logic               last;
  } out_item_t;
endpackage

// ----- rtl/bnk_if.sv -----
// ----------------------------------------------------------------------------
// bnk_in_if / bnk_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface bnk_in_if;
  import bnk_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bnk_out_if;
  import bnk_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/bnk_alu.sv -----
// ----------------------------------------------------------------------------
// bnk_alu
// Shared arithmetic unit: one add or subtract and one compare per cycle.
// ----------------------------------------------------------------------------
module bnk_alu #(
  parameter int W = 12
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] y,
  output logic         a_gt_b
);
  assign y      = sub ? (a - b) : (a + b);
  assign a_gt_b = a > b;
endmodule

// ----- rtl/bankers_safety_and_request_check.sv -----
// ----------------------------------------------------------------------------
// bankers_safety_and_request_check
// Banker's algorithm engine: loads state, runs safety checks and requests.
// ----------------------------------------------------------------------------
// Items arrive on in_ch and are taken one at a time; ready is low while an
// item is in work. Each item gives one result on out_ch, except a safe check
// or granted request, which gives one result per process of the safe
// sequence, the final one marked by last. A load item passes S_LOAD, then
// S_OUT puts its result in the output register, and the engine returns to
// S_IDLE to take the next item. A safety check uses a single shared
// add/compare unit: one resource compare per cycle, one add per resource for
// a process that can finish and one step in S_CHK_NEXT per process visited;
// the safe sequence is then emitted entry by entry. A request steps through
// the resources in its need and available phases, stopping at the first that
// exceeds, then through all of them in its apply phase before the check, and
// again on rollback when found unsafe. Results stand in an output register;
// while the receiver stalls the engine holds. Reset (rst, synchronous)
// clears the available, request, max and allocation arrays and sets the
// process and resource counts to 5 and 3. The user must see that configuration
// is written only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module bankers_safety_and_request_check #(
  parameter int MAX_PROCS  = 8,
  parameter int MAX_RES    = 4,
  parameter int COUNT_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  bnk_in_if.sink     in_ch,
  bnk_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data
);
  import bnk_pkg::*;

  localparam int PW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RW  = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int WW  = COUNT_BITS + 4;
  localparam int NE  = MAX_PROCS * MAX_RES;
  localparam int EW  = (NE > 1) ? $clog2(NE) : 1;
  localparam int PCW = $clog2(MAX_PROCS + 1);
  localparam int RCW = $clog2(MAX_RES + 1);

  logic [3:0] num_processes;
  logic [2:0] num_resources;
  logic [PCW-1:0] np;
  logic [RCW-1:0] nr;

  logic [COUNT_BITS-1:0] available [MAX_RES];
  logic [COUNT_BITS-1:0] request_vec [MAX_RES];
  logic [COUNT_BITS-1:0] max_claim [NE];
  logic [COUNT_BITS-1:0] allocation [NE];
  logic [WW-1:0] work_vec [MAX_RES];
  logic [MAX_PROCS-1:0] finished;
  logic [PW-1:0] safe_seq [MAX_PROCS];
  logic [PCW-1:0] seq_len;
  logic [PCW-1:0] emit_k;

  state_t state, state_next;
  in_item_t item;
  logic [PW-1:0] pi;
  logic [RW-1:0] ri;
  logic progress;
  logic grant_mode;
  out_item_t res;
  logic res_valid;

  // saturated sizes
  always_comb begin
    if (num_processes == 4'd0) np = PCW'(1);
    else if (32'(num_processes) > MAX_PROCS) np = PCW'(MAX_PROCS);
    else np = PCW'(num_processes);
    if (num_resources == 3'd0) nr = RCW'(1);
    else if (32'(num_resources) > MAX_RES) nr = RCW'(MAX_RES);
    else nr = RCW'(num_resources);
  end

  logic [PW-1:0] ip;
  logic [RW-1:0] ir;
  logic rok, pok;
  assign ip  = PW'(item.process_index);
  assign ir  = RW'(item.resource_index);
  assign rok = 32'(item.resource_index) < 32'(nr);
  assign pok = 32'(item.process_index) < 32'(np);

  logic [EW-1:0] eidx, cidx;
  assign eidx = EW'(32'(ip) * MAX_RES + 32'(ir));
  assign cidx = EW'(32'(pi) * MAX_RES + 32'(ri));

  logic [COUNT_BITS-1:0] amt;
  assign amt = COUNT_BITS'(item.amount);

  logic load_ok;
  always_comb begin
    load_ok = 1'b0;
    case (item.action)
      ACT_SET_AVAIL: load_ok = rok;
      ACT_SET_MAX: load_ok = rok && pok && !(amt < allocation[eidx]);
      ACT_SET_ALLOC: load_ok = rok && pok && !(amt > max_claim[eidx]);
      ACT_SET_REQ: load_ok = rok;
      default: load_ok = 1'b0;
    endcase
  end

  // shared unit operands
  logic [WW-1:0] alu_a, alu_b, alu_y;
  logic alu_sub, alu_gt;
  logic [COUNT_BITS-1:0] need;
  assign need = max_claim[cidx] - allocation[cidx];

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    alu_sub = 1'b0;
    case (state)
      S_REQ_NEED: begin
        alu_a = WW'(request_vec[ri]);
        alu_b = WW'(need);
      end
      S_REQ_AVAIL: begin
        alu_a = WW'(request_vec[ri]);
        alu_b = WW'(available[ri]);
      end
      S_CHK_CMP: begin
        alu_a = WW'(need);
        alu_b = work_vec[ri];
      end
      S_CHK_ADD: begin
        alu_a = work_vec[ri];
        alu_b = WW'(allocation[cidx]);
      end
      default: ;
    endcase
  end

  bnk_alu #(.W(WW)) u_alu (
    .a(alu_a), .b(alu_b), .sub(alu_sub), .y(alu_y), .a_gt_b(alu_gt)
  );

  logic last_r, last_p;
  assign last_r = 32'(ri) + 1 >= 32'(nr);
  assign last_p = 32'(pi) + 1 >= 32'(np);
  logic all_done;
  always_comb begin
    all_done = 1'b1;
    for (int p = 0; p < MAX_PROCS; p++)
      if (p < 32'(np) && !finished[p]) all_done = 1'b0;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_next = S_LOAD;
      S_LOAD: begin
        case (item.action)
          ACT_CHECK: state_next = S_CHK_INIT;
          ACT_SUBMIT: state_next = pok ? S_REQ_NEED : S_OUT;
          default: state_next = S_OUT;
        endcase
      end
      S_REQ_NEED:
        if (alu_gt) state_next = S_OUT;
        else if (last_r) state_next = S_REQ_AVAIL;
      S_REQ_AVAIL:
        if (alu_gt) state_next = S_OUT;
        else if (last_r) state_next = S_REQ_APPLY;
      S_REQ_APPLY: if (last_r) state_next = S_CHK_INIT;
      S_CHK_INIT: state_next = S_CHK_CMP;
      S_CHK_CMP:
        if (finished[pi] || alu_gt) state_next = S_CHK_NEXT;
        else if (last_r) state_next = S_CHK_ADD;
      S_CHK_ADD: if (last_r) state_next = S_CHK_NEXT;
      S_CHK_NEXT:
        if (!last_p) state_next = S_CHK_CMP;
        else if (progress) state_next = S_CHK_CMP;
        else state_next = S_CHK_END;
      S_CHK_END:
        if (all_done) state_next = S_EMIT;
        else if (grant_mode) state_next = S_ROLLBACK;
        else state_next = S_OUT;
      S_ROLLBACK: if (last_r) state_next = S_OUT;
      S_EMIT: if (!res_valid || out_ch.ready) begin
        if (32'(emit_k) + 1 >= 32'(seq_len)) state_next = S_OUT;
      end
      S_OUT: if (!res_valid || out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // the last emitted entry is followed by a no-op pass through S_OUT
  logic out_free;
  assign out_free = !res_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && out_free;
  assign out_ch.valid = res_valid;
  assign out_ch.data = res;

  logic res_load;
  assign res_load = out_free && ((state == S_EMIT) || (state == S_OUT && !final_skip));

  logic [StatusW-1:0] final_st;
  logic final_skip;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      num_processes <= 4'd5;
      num_resources <= 3'd3;
      res_valid <= 1'b0;
      for (int i = 0; i < MAX_RES; i++) begin
        available[i] <= '0;
        request_vec[i] <= '0;
      end
      for (int i = 0; i < NE; i++) begin
        max_claim[i] <= '0;
        allocation[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (res_load) res_valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) res_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_NUM_PROCS) num_processes <= cfg_data;
        else num_resources <= cfg_data[2:0];
      end
      case (state)
        S_IDLE: if (in_ch.valid && in_ch.ready) item <= in_ch.data;
        S_LOAD: begin
          ri <= '0;
          pi <= ip;
          grant_mode <= 1'b0;
          final_skip <= 1'b0;
          final_st <= load_ok ? ST_LOADED : ST_INVALID;
          if (load_ok) begin
            case (item.action)
              ACT_SET_AVAIL: available[ir] <= amt;
              ACT_SET_MAX: max_claim[eidx] <= amt;
              ACT_SET_ALLOC: allocation[eidx] <= amt;
              ACT_SET_REQ: request_vec[ir] <= amt;
              default: ;
            endcase
          end
        end
        S_REQ_NEED: begin
          if (alu_gt) final_st <= ST_EXCEEDS;
          ri <= last_r ? '0 : ri + 1'b1;
        end
        S_REQ_AVAIL: begin
          if (alu_gt) final_st <= ST_WAIT;
          ri <= last_r ? '0 : ri + 1'b1;
        end
        S_REQ_APPLY: begin
          available[ri] <= available[ri] - request_vec[ri];
          allocation[cidx] <= allocation[cidx] + request_vec[ri];
          ri <= last_r ? '0 : ri + 1'b1;
          grant_mode <= 1'b1;
        end
        S_CHK_INIT: begin
          for (int i = 0; i < MAX_RES; i++) work_vec[i] <= WW'(available[i]);
          finished <= '0;
          seq_len <= '0;
          pi <= '0;
          ri <= '0;
          progress <= 1'b0;
          emit_k <= '0;
        end
        S_CHK_CMP: begin
          if (finished[pi] || alu_gt || last_r) ri <= '0;
          else ri <= ri + 1'b1;
        end
        S_CHK_ADD: begin
          work_vec[ri] <= alu_y;
          ri <= last_r ? '0 : ri + 1'b1;
          if (last_r) begin
            finished[pi] <= 1'b1;
            safe_seq[seq_len[PW-1:0]] <= pi;
            seq_len <= seq_len + 1'b1;
            progress <= 1'b1;
          end
        end
        S_CHK_NEXT: begin
          ri <= '0;
          if (last_p) begin
            pi <= '0;
            progress <= 1'b0;
          end else pi <= pi + 1'b1;
        end
        S_CHK_END: begin
          ri <= '0;
          pi <= PW'(item.process_index);
          final_st <= ST_UNSAFE;
          if (all_done) final_skip <= 1'b1;
        end
        S_ROLLBACK: begin
          available[ri] <= available[ri] + request_vec[ri];
          allocation[cidx] <= allocation[cidx] - request_vec[ri];
          ri <= last_r ? '0 : ri + 1'b1;
        end
        S_EMIT: if (out_free) begin
          res.status <= grant_mode ? ST_GRANTED : ST_SAFE;
          res.seq_process <= ProcW'(safe_seq[emit_k[PW-1:0]]);
          res.seq_valid <= 1'b1;
          res.last <= 32'(emit_k) + 1 >= 32'(seq_len);
          emit_k <= emit_k + 1'b1;
        end
        S_OUT: if (out_free && !final_skip) begin
          res.status <= final_st;
          res.seq_process <= '0;
          res.seq_valid <= 1'b0;
          res.last <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
